/* src/tachometer_moving_sum_stop_detect_assert.svh */
// Assertion macros for the tachometer block.
// Included by the top level; no other dependencies.
`ifndef TACHOMETER_MOVING_SUM_STOP_DETECT_ASSERT_SVH
`define TACHOMETER_MOVING_SUM_STOP_DETECT_ASSERT_SVH

// same-cycle implication
`define TMSSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TMSSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tmssd_pkg.sv */
// Shared types, codes and constants for the tachometer block.
// No dependencies.
`timescale 1ns / 1ps
package tmssd_pkg;

  localparam int OP_W     = 2;
  localparam int COUNT_W  = 16;
  localparam int SPEED_W  = 8;
  localparam int DIST_W   = 16;
  localparam int METERS_W = 13;
  localparam int TREND_W  = 2;

  localparam logic [SPEED_W-1:0] SPEED_CAP = 8'd255;

  // distance / 14 as (d * ceil(2^20 / 14)) >> 20, exact for 16-bit d
  localparam logic [32:0] DIV14_MUL = 33'd74899;
  localparam int          DIV14_SH  = 20;

  localparam logic [TREND_W-1:0] TREND_STEADY = 2'd0;
  localparam logic [TREND_W-1:0] TREND_UP     = 2'd1;
  localparam logic [TREND_W-1:0] TREND_DOWN   = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE     = 2'd0,
    OP_UPDATE     = 2'd1,
    OP_CLEAR_ALL  = 2'd2,
    OP_CLEAR_DIST = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SUM,
    ST_TREND,
    ST_THR,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_ADD_SAT,
    ALU_CMP
  } alu_op_t;

  typedef struct packed {
    logic    take;
    logic    exec;
    logic    sum;
    logic    sum_first;
    logic    trend;
    logic    thr;
    logic    load_out;
    alu_op_t alu_op;
    op_t     op;
  } ctrl_t;

  function automatic logic [METERS_W-1:0] div14(input logic [DIST_W-1:0] d);
    logic [32:0] p;
    p = 33'(d) * DIV14_MUL;
    return p[DIV14_SH + METERS_W - 1:DIV14_SH];
  endfunction

endpackage

/* src/tmssd_if.sv */
// Valid/ready channel interfaces: input items, results and threshold writes.
// Depends on tmssd_pkg.
`timescale 1ns / 1ps
interface tmssd_in_if;
  import tmssd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [COUNT_W-1:0]   pulse_count;
  modport source (output valid, operation, pulse_count, input ready);
  modport sink   (input valid, operation, pulse_count, output ready);
endinterface

interface tmssd_out_if;
  import tmssd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SPEED_W-1:0]   speed;
  logic [DIST_W-1:0]    distance;
  logic [METERS_W-1:0]  distance_meters;
  logic [TREND_W-1:0]   trend;
  logic                 is_running;
  logic                 stop_latched;
  modport source (output valid, speed, distance, distance_meters, trend, is_running,
                  stop_latched, input ready);
  modport sink   (input valid, speed, distance, distance_meters, trend, is_running,
                  stop_latched, output ready);
endinterface

interface tmssd_cfg_if;
  import tmssd_pkg::*;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/tmssd_alu.sv */
// Shared arithmetic unit: wrapping add, add saturating at the speed cap, compare.
// Depends on tmssd_pkg.
`timescale 1ns / 1ps
module tmssd_alu (
  input  tmssd_pkg::alu_op_t              op,
  input  logic [tmssd_pkg::COUNT_W-1:0]   a,
  input  logic [tmssd_pkg::COUNT_W-1:0]   b,
  output logic [tmssd_pkg::COUNT_W-1:0]   y,
  output logic                            gt,
  output logic                            lt
);
  import tmssd_pkg::*;

  logic [COUNT_W:0] s;

  assign s  = {1'b0, a} + {1'b0, b};
  assign gt = (a > b);
  assign lt = (a < b);

  always_comb begin
    case (op)
      ALU_ADD:     y = s[COUNT_W-1:0];
      ALU_ADD_SAT: y = (s > {{(COUNT_W+1-SPEED_W){1'b0}}, SPEED_CAP}) ?
                       {{(COUNT_W-SPEED_W){1'b0}}, SPEED_CAP} : s[COUNT_W-1:0];
      default:     y = a;
    endcase
  end
endmodule

/* src/tmssd_seq.sv */
// Sequencer: walks one transaction through execute (sample, clear) or ring sum,
// trend and threshold (update), then the result step. Depends on tmssd_pkg.
`timescale 1ns / 1ps
module tmssd_seq #(
  parameter int AVG_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_fire,
  input  tmssd_pkg::op_t                        in_op,
  input  logic                                  out_free,
  output tmssd_pkg::ctrl_t                      ctrl,
  output logic [((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1)-1:0] idx
);
  import tmssd_pkg::*;

  localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(AVG_DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  op_t           op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      op_r    <= OP_SAMPLE;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_op;
          cnt_nxt   = '0;
          state_nxt = (in_op == OP_UPDATE) ? ST_SUM : ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_OUT;
      ST_SUM: begin
        if (cnt_r == LAST) begin
          state_nxt = ST_TREND;
        end else begin
          cnt_nxt = cnt_r + PW'(1);
        end
      end
      ST_TREND: state_nxt = ST_THR;
      ST_THR:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.op        = op_r;
    ctrl.alu_op    = ALU_ADD;
    case (state_r)
      ST_IDLE: ctrl.take = 1'b1;
      ST_EXEC: begin
        ctrl.exec   = 1'b1;
        ctrl.alu_op = ALU_ADD;
      end
      ST_SUM: begin
        ctrl.sum       = 1'b1;
        ctrl.sum_first = (cnt_r == '0);
        ctrl.alu_op    = ALU_ADD_SAT;
      end
      ST_TREND: begin
        ctrl.trend  = 1'b1;
        ctrl.alu_op = ALU_CMP;
      end
      ST_THR: begin
        ctrl.thr    = 1'b1;
        ctrl.alu_op = ALU_CMP;
      end
      ST_OUT: ctrl.load_out = out_free;
      default: ctrl.take = 1'b0;
    endcase
  end

  assign idx = cnt_r;
endmodule

/* src/tachometer_moving_sum_stop_detect.sv */
// Pulse-count tachometer with moving-sum speed, distance and stop detection.
// Usage:
//   in_ch  : valid/ready input, one transaction carries operation and pulse_count
//            (sample, update speed, clear all, clear distance).
//   out_ch : valid/ready result, one per input transaction, showing speed,
//            distance, distance / 14, trend and the running/stopped flags.
//   cfg_ch : valid/ready write of stop_threshold, always ready; write when idle.
// From accept to result valid: sample and clear transactions pass the execute
// step; an update sums the ring one entry per cycle through the shared adder,
// then does the trend and threshold compares. A new transaction is taken only
// after the last one has loaded its result; in_ch.ready is high only while the
// sequencer is idle.
// The result sits in an output register; a new transaction is accepted while
// it waits, but the sequencer holds its result step until out_ch is free, so a
// stalled receiver stalls the block without loss.
// Reset (rst_n low, synchronous) clears the ring, pointer, distance, speed,
// trend, flags and threshold, and drops out_ch.valid.
// Depends on tmssd_pkg, tmssd_if, tmssd_alu, tmssd_seq and the assertion header.
`timescale 1ns / 1ps
`include "tachometer_moving_sum_stop_detect_assert.svh"
module tachometer_moving_sum_stop_detect #(
  parameter int AVG_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  tmssd_in_if.sink    in_ch,
  tmssd_out_if.source out_ch,
  tmssd_cfg_if.sink   cfg_ch
);
  import tmssd_pkg::*;

  localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(AVG_DEPTH - 1);

  ctrl_t               ctrl;
  logic [PW-1:0]       idx;
  logic                in_fire;
  logic                out_free;

  logic [COUNT_W-1:0]  ring_r [AVG_DEPTH];
  logic [PW-1:0]       ptr_r;
  logic [PW-1:0]       ptr_inc;
  logic [COUNT_W-1:0]  pulse_r;
  logic [DIST_W-1:0]   dist_r;
  logic [SPEED_W-1:0]  acc_r;
  logic [SPEED_W-1:0]  speed_r;
  logic [TREND_W-1:0]  trend_r;
  logic                run_r;
  logic                stop_r;
  logic [SPEED_W-1:0]  thr_r;

  logic                out_valid_r;
  logic [SPEED_W-1:0]  o_speed_r;
  logic [DIST_W-1:0]   o_dist_r;
  logic [METERS_W-1:0] o_meters_r;
  logic [TREND_W-1:0]  o_trend_r;
  logic                o_run_r;
  logic                o_stop_r;

  logic [COUNT_W-1:0]  alu_a;
  logic [COUNT_W-1:0]  alu_b;
  logic [COUNT_W-1:0]  alu_y;
  logic                alu_gt;
  logic                alu_lt;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = ctrl.take;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign ptr_inc      = (ptr_r == LAST) ? '0 : ptr_r + PW'(1);

  tmssd_seq #(.AVG_DEPTH(AVG_DEPTH)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_op    (op_t'(in_ch.operation)),
    .out_free (out_free),
    .ctrl     (ctrl),
    .idx      (idx)
  );

  always_comb begin
    alu_a = dist_r;
    alu_b = pulse_r;
    if (ctrl.sum) begin
      alu_a = ctrl.sum_first ? '0 : {{(COUNT_W-SPEED_W){1'b0}}, acc_r};
      alu_b = ring_r[idx];
    end else if (ctrl.trend) begin
      alu_a = {{(COUNT_W-SPEED_W){1'b0}}, acc_r};
      alu_b = {{(COUNT_W-SPEED_W){1'b0}}, speed_r};
    end else if (ctrl.thr) begin
      alu_a = {{(COUNT_W-SPEED_W){1'b0}}, speed_r};
      alu_b = {{(COUNT_W-SPEED_W){1'b0}}, thr_r};
    end
  end

  tmssd_alu u_alu (
    .op (ctrl.alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y),
    .gt (alu_gt),
    .lt (alu_lt)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pulse_r <= in_ch.pulse_count;
    end
    if (ctrl.sum) begin
      acc_r <= alu_y[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      ptr_r   <= '0;
      dist_r  <= '0;
      speed_r <= '0;
      trend_r <= TREND_STEADY;
      run_r   <= 1'b0;
      stop_r  <= 1'b0;
      thr_r   <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        thr_r <= cfg_ch.data;
      end
      if (ctrl.exec) begin
        case (ctrl.op)
          OP_SAMPLE: begin
            ptr_r           <= ptr_inc;
            ring_r[ptr_inc] <= pulse_r;
            dist_r          <= alu_y;
          end
          OP_CLEAR_ALL: begin
            for (int i = 0; i < AVG_DEPTH; i++) begin
              ring_r[i] <= '0;
            end
            ptr_r   <= '0;
            dist_r  <= '0;
            speed_r <= '0;
            trend_r <= TREND_STEADY;
            run_r   <= 1'b0;
            stop_r  <= 1'b0;
          end
          default: dist_r <= '0;
        endcase
      end
      if (ctrl.trend) begin
        speed_r <= acc_r;
        trend_r <= alu_gt ? TREND_UP : (alu_lt ? TREND_DOWN : TREND_STEADY);
      end
      if (ctrl.thr) begin
        if (!run_r) begin
          if (alu_gt) begin
            run_r <= 1'b1;
          end
        end else if (!alu_gt) begin
          stop_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      o_speed_r  <= speed_r;
      o_dist_r   <= dist_r;
      o_meters_r <= div14(dist_r);
      o_trend_r  <= trend_r;
      o_run_r    <= run_r;
      o_stop_r   <= stop_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.speed           = o_speed_r;
  assign out_ch.distance        = o_dist_r;
  assign out_ch.distance_meters = o_meters_r;
  assign out_ch.trend           = o_trend_r;
  assign out_ch.is_running      = o_run_r;
  assign out_ch.stop_latched    = o_stop_r;

  `TMSSD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ch.ready, "accepted while busy")
  `TMSSD_ASSERT_NEXT(a_result_loaded, clk, rst_n, ctrl.load_out, out_ch.valid, "result not presented")
  `TMSSD_ASSERT_NOW(a_stop_needs_run, clk, rst_n, stop_r, run_r, "stopped without running")
endmodule
